// ===== hdl/stbs_pkg.sv =====
// ============================================================================
// stbs_pkg: shared types and constants for the sorted table search unit
// Table geometry, beat payload types, opcodes, register map, and the
// command/status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int BND_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths
  localparam int VAL_W = 32;
  localparam int EIDX_W = 10;
  localparam int POS_W = 10;
  localparam int LEN_W = 11;

  // APB register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_TABLE_LENGTH = 1'b0;

  // Item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Input beat
  typedef struct packed {
    logic                    operation;
    logic [EIDX_W-1:0]       entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] search_key;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic start;      // search beat taken: load key and bounds
    logic probe_rd;   // read the table at the midpoint
    logic probe_cmp;  // compare read data and narrow the range
    logic out_load;   // move the result into the output register
  } stbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_open;  // left bound below exclusive right bound
    logic hit;         // read entry equals the key
    logic out_free;    // output register can take a result
  } stbs_stat_t;

endpackage

`default_nettype wire

// ===== hdl/stbs_ctrl.sv =====
// ============================================================================
// stbs_ctrl: search sequencer
// One-hot state machine that takes input beats while idle and steps the
// datapath through read/compare probes until a hit or an empty range.
// ============================================================================
`default_nettype none

module stbs_ctrl
  import stbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_op,
  input  wire stbs_stat_t stat,
  output stbs_cmd_t       cmd,
  output logic            in_stall
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Take beats only while idle
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_SEARCH) begin
            cmd.start = 1'b1;
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (stat.range_open) begin
          cmd.probe_rd = 1'b1;
          state_nxt    = ST_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CMP: begin
        cmd.probe_cmp = 1'b1;
        state_nxt     = stat.hit ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stbs_dp.sv =====
// ============================================================================
// stbs_dp: table memory and search datapath
// Holds the table RAM, the search bounds, key and result, and the output
// register of the result channel.
// ============================================================================
`default_nettype none

module stbs_dp
  import stbs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire in_item_t         in_data,
  input  wire logic [LEN_W-1:0] table_length,
  input  wire stbs_cmd_t        cmd,
  output stbs_stat_t            stat,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  wire logic             out_stall
);

  logic [VAL_W-1:0]        mem [TABLE_DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;
  logic signed [VAL_W-1:0] key_r;
  logic [BND_W-1:0]        left_r;
  logic [BND_W-1:0]        hi_r;
  logic [IDX_W-1:0]        center_r;
  logic                    found_r;
  logic [IDX_W-1:0]        pos_r;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r;

  logic [BND_W-1:0] len_sat;
  logic [BND_W:0]   mid_sum;
  logic [IDX_W-1:0] center_w;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  // Clamp the live length to the table depth
  assign len_sat = (32'(table_length) > 32'(TABLE_DEPTH)) ? BND_W'(TABLE_DEPTH)
                                                          : BND_W'(table_length);

  // Midpoint of [left, hi-1], rounded down
  assign mid_sum  = {1'b0, left_r} + {1'b0, hi_r} - (BND_W + 1)'(1);
  assign center_w = mid_sum[IDX_W:1];

  // Table write from a write beat; drop indexes beyond the depth
  assign wr_en   = cmd.accept && (in_data.operation == OP_WRITE)
                   && (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = IDX_W'(in_data.entry_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.entry_value;
    end
  end

  // Registered table read at the midpoint
  always_ff @(posedge clk) begin
    if (cmd.probe_rd) begin
      rd_data_r <= mem[center_w];
      center_r  <= center_w;
    end
  end

  // Status to the controller
  assign stat.range_open = (left_r < hi_r);
  assign stat.hit        = (rd_data_r == key_r);
  assign stat.out_free   = !out_valid_r || !out_stall;

  // Load key and bounds, then narrow the range on each compare
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r   <= in_data.search_key;
      left_r  <= '0;
      hi_r    <= len_sat;
      found_r <= 1'b0;
      pos_r   <= '0;
    end else if (cmd.probe_cmp) begin
      if (rd_data_r == key_r) begin
        found_r <= 1'b1;
        pos_r   <= center_r;
      end else if (rd_data_r < key_r) begin
        left_r <= BND_W'(center_r) + BND_W'(1);
      end else begin
        hi_r <= BND_W'(center_r);
      end
    end
  end

  // Output register: hold while stalled, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.found    <= found_r;
      out_data_r.position <= POS_W'(pos_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/sorted_table_binary_search_unit.sv =====
// ============================================================================
// sorted_table_binary_search_unit: binary search over a sorted RAM table
// Top level: APB length register, sequencer and datapath.
// ============================================================================
// Write beats (operation 0) store a signed value into the 1024-entry table
// and give no result. Search beats (operation 1) probe the midpoint of
// [0, table_length-1], clamped to the depth, and return one beat with found
// and position (position is 0 when not found). Each probe is a registered
// RAM read followed by a compare; a search needs at most 11 probes at this
// depth. The block takes one beat at a time; a write is taken while a
// result still waits on the output. The table has no reset: keep
// table_length covering written entries only, and write table_length only
// while the block is idle.
// ============================================================================
`default_nettype none

module sorted_table_binary_search_unit
  import stbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data,
  // APB register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  stbs_cmd_t        cmd;
  stbs_stat_t       stat;
  logic [LEN_W-1:0] table_length_r, table_length_nxt;

  // Register write on the access phase
  assign pready = 1'b1;

  always_comb begin
    table_length_nxt = table_length_r;
    if (psel && penable && pwrite && (paddr[2] == REG_TABLE_LENGTH)) begin
      table_length_nxt = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else begin
      table_length_r <= table_length_nxt;
    end
  end

  // Register read
  assign prdata = (paddr[2] == REG_TABLE_LENGTH) ? PDATA_W'(table_length_r) : '0;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  stbs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .table_length (table_length_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_stall    (out_stall)
  );

endmodule

`default_nettype wire

// ===== hdl/stbs_chk.sv =====
// ============================================================================
// stbs_chk: port-level checker for the search unit
// Watches the top level's ports for result hold, result shape and the
// busy window of a search.
// ============================================================================
`default_nettype none

module stbs_chk
  import stbs_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire in_item_t           in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire out_item_t          out_data,
  input wire logic               psel,
  input wire logic               penable,
  input wire logic               pwrite,
  input wire logic [PADDR_W-1:0] paddr,
  input wire logic [PDATA_W-1:0] pwdata,
  input wire logic [PDATA_W-1:0] prdata,
  input wire logic               pready
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.position == '0)
    else $error("miss with nonzero position");

  // An accepted search keeps the input stalled on the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == OP_SEARCH) |=> in_stall)
    else $error("input not stalled after search accept");

  // A new result appears only out of a busy cycle
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a search in flight");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_table_binary_search_unit stbs_chk u_stbs_chk (.*);

`default_nettype wire
